>>> src/timer_capture_fifo_defines.svh
// ----------------------------------------------------------------------------
// timer capture fifo assertion macros
// shared concurrent assertion helpers, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef TIMER_CAPTURE_FIFO_DEFINES_SVH
`define TIMER_CAPTURE_FIFO_DEFINES_SVH

`ifndef ASSERT_OFF
`define TCF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TCF_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) pre |=> post) else $error(msg);
`else
`define TCF_ASSERT(label, prop, msg)
`define TCF_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

>>> src/tcf_pkg.sv
// ----------------------------------------------------------------------------
// tcf_pkg
// types and constants of the timer capture fifo
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcf_pkg;

	localparam int DATA_W  = 32;
	localparam int HALF_W  = 16;
	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;

	localparam logic [PADDR_W-1:0] REG_CAPTURE_MODE = 2'd0;

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_FIRST  = 2'd1,
		MODE_SECOND = 2'd2,
		MODE_BOTH   = 2'd3
	} tcf_mode_t;

	typedef struct packed {
		logic              push;
		logic [DATA_W-1:0] data;
	} tcf_push_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic popped;
	} tcf_qstat_t;

endpackage

>>> src/tcf_in_if.sv
// ----------------------------------------------------------------------------
// tcf_in_if
// tick channel into the capture fifo: valid, ready and capture inputs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tcf_in_if;
	logic        valid;
	logic        ready;
	logic        edge_seen;
	logic        first_valid;
	logic [31:0] first_value;
	logic        second_valid;
	logic [31:0] second_value;
	logic        bus_read;

	modport source (
		output valid, edge_seen, first_valid, first_value,
		       second_valid, second_value, bus_read,
		input  ready
	);

	modport sink (
		input  valid, edge_seen, first_valid, first_value,
		       second_valid, second_value, bus_read,
		output ready
	);
endinterface

>>> src/tcf_out_if.sv
// ----------------------------------------------------------------------------
// tcf_out_if
// result channel of the capture fifo: strobes, bus data and queue flags
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tcf_out_if;
	logic        valid;
	logic        ready;
	logic        request_first;
	logic        request_second;
	logic [31:0] bus_data;
	logic        bus_data_valid;
	logic        queue_empty;
	logic        queue_full;

	modport source (
		output valid, request_first, request_second, bus_data,
		       bus_data_valid, queue_empty, queue_full,
		input  ready
	);

	modport sink (
		input  valid, request_first, request_second, bus_data,
		       bus_data_valid, queue_empty, queue_full,
		output ready
	);
endinterface

>>> src/timer_capture_fifo.sv
// ----------------------------------------------------------------------------
// timer_capture_fifo
// capture buffer of an input-capture unit: timer strobes and a ring queue
// ----------------------------------------------------------------------------
// channel  | modport | transfer
// in_ch    | sink    | one clock tick of capture inputs and bus read
// out_ch   | source  | one result per tick: strobes, bus data, flags
// apb      | slave   | capture mode register at byte address 0
//
// one tick accepted per cycle while out_ch is not stalled; each tick then passes through
// input register, then queue update and ram read, then result register
// the ram read port registers the popped entry into the result stage
// reset clears pointers, valids and mode; the entry ram is not cleared
// a stalled result holds the stages behind it, ready drops when both are full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timer_capture_fifo
	import tcf_pkg::*;
#(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	tcf_in_if.sink             in_ch,
	tcf_out_if.source          out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	tcf_mode_t         mode;
	tcf_push_t         push_req;
	tcf_qstat_t        stat;
	logic [DATA_W-1:0] rdata;

	logic              valid_s1;
	logic              edge_s1;
	logic              fv_s1;
	logic [DATA_W-1:0] fval_s1;
	logic              sv_s1;
	logic [DATA_W-1:0] sval_s1;
	logic              rd_s1;

	logic              valid_s2;
	logic              req_first_s2;
	logic              req_second_s2;
	logic              pop_s2;
	logic              rd_s2;
	logic              empty_s2;
	logic              full_s2;

	logic              step;
	logic              req_first;
	logic              req_second;

	tcf_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.mode    (mode)
	);

	assign step        = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			edge_s1 <= in_ch.edge_seen;
			fv_s1   <= in_ch.first_valid;
			fval_s1 <= in_ch.first_value;
			sv_s1   <= in_ch.second_valid;
			sval_s1 <= in_ch.second_value;
			rd_s1   <= in_ch.bus_read;
		end
	end

	always_comb begin
		push_req = '0;
		case (mode)
			MODE_FIRST: begin
				push_req.push = fv_s1;
				push_req.data = fval_s1;
			end
			MODE_SECOND: begin
				push_req.push = sv_s1;
				push_req.data = sval_s1;
			end
			MODE_BOTH: begin
				push_req.push = fv_s1 && sv_s1;
				push_req.data = {fval_s1[HALF_W-1:0], sval_s1[HALF_W-1:0]};
			end
			default: begin
				push_req = '0;
			end
		endcase
	end

	assign req_first  = edge_s1 && (mode == MODE_FIRST || mode == MODE_BOTH);
	assign req_second = edge_s1 && (mode == MODE_SECOND || mode == MODE_BOTH);

	tcf_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.pop_req  (rd_s1),
		.push_req (push_req),
		.stat     (stat),
		.rdata    (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ch.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			req_first_s2  <= req_first;
			req_second_s2 <= req_second;
			pop_s2        <= stat.popped;
			rd_s2         <= rd_s1;
			empty_s2      <= stat.empty;
			full_s2       <= stat.full;
		end
	end

	assign out_ch.valid          = valid_s2;
	assign out_ch.request_first  = req_first_s2;
	assign out_ch.request_second = req_second_s2;
	assign out_ch.bus_data       = pop_s2 ? rdata : '0;
	assign out_ch.bus_data_valid = rd_s2;
	assign out_ch.queue_empty    = empty_s2;
	assign out_ch.queue_full     = full_s2;

endmodule

>>> src/tcf_ram.sv
// ----------------------------------------------------------------------------
// tcf_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/tcf_cfg_regs.sv
// ----------------------------------------------------------------------------
// tcf_cfg_regs
// apb register file holding the capture mode
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcf_cfg_regs
	import tcf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output tcf_mode_t          mode
);

	tcf_mode_t mode_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OFF;
		end else if (psel && penable && pwrite && pready && paddr == REG_CAPTURE_MODE) begin
			mode_q <= tcf_mode_t'(pwdata[1:0]);
		end
	end

	always_comb begin
		prdata = '0;
		case (paddr)
			REG_CAPTURE_MODE: prdata = {{(PDATA_W-2){1'b0}}, mode_q};
			default:          prdata = '0;
		endcase
	end

	assign mode = mode_q;

endmodule

>>> src/tcf_queue.sv
// ----------------------------------------------------------------------------
// tcf_queue
// ring queue pointers and flags around the entry ram, pop before push
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "timer_capture_fifo_defines.svh"

module tcf_queue
	import tcf_pkg::*;
#(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              pop_req,
	input  tcf_push_t         push_req,
	output tcf_qstat_t        stat,
	output logic [DATA_W-1:0] rdata
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [PTR_W-1:0] wp_nx;
	logic [PTR_W-1:0] rp_nx;
	logic             do_pop;
	logic             do_push;

	assign wp_nx = (wp_q == LAST) ? '0 : wp_q + 1'b1;
	assign rp_nx = (rp_q == LAST) ? '0 : rp_q + 1'b1;

	assign stat.empty  = (wp_q == rp_q);
	assign stat.full   = (wp_nx == rp_q);
	assign do_pop      = step && pop_req && !stat.empty;
	assign do_push     = step && push_req.push && (!stat.full || do_pop);
	assign stat.popped = do_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_nx;
			end
			if (do_pop) begin
				rp_q <= rp_nx;
			end
		end
	end

	tcf_ram #(
		.WIDTH (DATA_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (do_push),
		.waddr (wp_q),
		.wdata (push_req.data),
		.re    (do_pop),
		.raddr (rp_q),
		.rdata (rdata)
	);

	`TCF_ASSERT(a_flags_exclusive, !(stat.empty && stat.full), "queue empty and full at once")
	`TCF_ASSERT(a_ptr_range, (wp_q <= LAST) && (rp_q <= LAST), "queue pointer out of range")
	`TCF_ASSERT_NEXT(a_wp_hold, !do_push, $stable(wp_q), "write pointer moved without push")
	`TCF_ASSERT_NEXT(a_rp_hold, !do_pop, $stable(rp_q), "read pointer moved without pop")

endmodule
